// File: sv/positional_list_engine_core_defines.svh
// ----------------------------------------------------------------------------
// positional_list_engine_core_defines
// Assertion macros shared by the checker of the positional list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLE_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, types and helper functions of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Storage geometry.
    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int PICK_W     = 1 << IDX_W;

    // Field widths of the stream items.
    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int FPOS_W = 8;
    localparam int LEN_W  = 9;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    localparam int S_TDATA_W = ((CMD_W + POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STAT_W + VAL_W + FPOS_W + LEN_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_AFTER  = 3'd0,
        CMD_INS_BEFORE = 3'd1,
        CMD_READ       = 3'd2,
        CMD_FIND       = 3'd3,
        CMD_WRITE      = 3'd4,
        CMD_DELETE     = 3'd5,
        CMD_SEED       = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_FIN  = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_WR   = 2'd3
    } cell_op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t               op;
        logic [IDX_W-1:0]       at;
    } cell_ctrl_t;

    // Input value kept at the stored word width.
    function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [VAL_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // Stored word sign-extended (or cut) back to the field width.
    function automatic logic [VAL_W-1:0] to_field(input logic [DATA_WIDTH-1:0] w);
        logic signed [DATA_WIDTH-1:0] sw;
        sw = w;
        return VAL_W'(sw);
    endfunction

endpackage

// File: sv/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a word, shifts with its neighbors and compares a key.
// ----------------------------------------------------------------------------
module ple_cell (
    input  logic                           clk,
    input  ple_pkg::cell_ctrl_t            ctrl,
    input  logic [ple_pkg::IDX_W-1:0]      cell_index,
    input  logic [ple_pkg::CNT_W-1:0]      count,
    input  logic [ple_pkg::DATA_WIDTH-1:0] key,
    input  logic [ple_pkg::DATA_WIDTH-1:0] left_word,
    input  logic [ple_pkg::DATA_WIDTH-1:0] right_word,
    output logic [ple_pkg::DATA_WIDTH-1:0] word,
    output logic                           match
);

    logic [ple_pkg::DATA_WIDTH-1:0] word_reg;
    logic [ple_pkg::DATA_WIDTH-1:0] word_next;

    // Pick the next content from the broadcast operation and this slot's place.
    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            ple_pkg::CELL_INS:
            begin
                if (cell_index > ctrl.at)
                    word_next = left_word;
                else if (cell_index == ctrl.at)
                    word_next = key;
            end
            ple_pkg::CELL_DEL:
            begin
                if (cell_index >= ctrl.at)
                    word_next = right_word;
            end
            ple_pkg::CELL_WR:
            begin
                if (cell_index == ctrl.at)
                    word_next = key;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // Slot content needs no reset; slots beyond the count are never used.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = (word_reg == key) && (ple_pkg::CNT_W'(cell_index) < count);

endmodule

// File: sv/ple_first_pick.sv
// ----------------------------------------------------------------------------
// ple_first_pick
// Binary tree that finds the lowest slot with a set match bit.
// ----------------------------------------------------------------------------
module ple_first_pick (
    input  logic [ple_pkg::CAPACITY-1:0] match_bits,
    output logic                         hit,
    output logic [ple_pkg::IDX_W-1:0]    hit_index
);

    logic                        node_v [0:ple_pkg::IDX_W][0:ple_pkg::PICK_W-1];
    logic [ple_pkg::IDX_W-1:0]   node_i [0:ple_pkg::IDX_W][0:ple_pkg::PICK_W-1];

    // Leaves, padded with empty slots up to a power of two.
    for (genvar n = 0; n < ple_pkg::PICK_W; n++)
    begin : g_leaf
        if (n < ple_pkg::CAPACITY)
        begin : g_real
            assign node_v[0][n] = match_bits[n];
        end
        else
        begin : g_pad
            assign node_v[0][n] = 1'b0;
        end
        assign node_i[0][n] = ple_pkg::IDX_W'(n);
    end

    // Each level keeps the left child when it has a match.
    for (genvar l = 0; l < ple_pkg::IDX_W; l++)
    begin : g_level
        for (genvar n = 0; n < (ple_pkg::PICK_W >> (l + 1)); n++)
        begin : g_node
            assign node_v[l+1][n] = node_v[l][2*n] | node_v[l][2*n+1];
            assign node_i[l+1][n] = node_v[l][2*n] ? node_i[l][2*n] : node_i[l][2*n+1];
        end
    end

    assign hit       = node_v[ple_pkg::IDX_W][0];
    assign hit_index = node_i[ple_pkg::IDX_W][0];

endmodule

// File: sv/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed words kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Group                 Content (lowest bit first)
// s_*      in   tvalid/tready/tdata   command, position, value
// m_*      out  tvalid/tready/tdata   status, data_out, found_position, list_length
//
// Each request passes through an execute state, in which all cells shift,
// write and compare at once, and a final state for the first-match tree
// and the result register. A new request is taken in the final state when
// the result register is free, so it overlaps the end of the previous one.
// A held result (m_tready low) stalls the engine in its final state.
// Reset empties the list; slot contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command [2:0], position [10:3], value [42:11], zero fill above
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], data_out [33:2], found_position [41:34], list_length [50:42]
    output logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CMD_LO  = 0;
    localparam int POS_LO  = CMD_LO + ple_pkg::CMD_W;
    localparam int VAL_LO  = POS_LO + ple_pkg::POS_W;
    localparam int PAY_W   = ple_pkg::STAT_W + ple_pkg::VAL_W + ple_pkg::FPOS_W
                             + ple_pkg::LEN_W;

    ple_pkg::state_t                  state_reg;
    ple_pkg::state_t                  state_next;
    ple_pkg::cmd_t                    cmd_reg;
    logic [ple_pkg::POS_W-1:0]        pos_reg;
    logic [ple_pkg::DATA_WIDTH-1:0]   key_reg;
    logic [ple_pkg::CNT_W-1:0]        count_reg;
    logic [ple_pkg::CNT_W-1:0]        count_next;
    ple_pkg::status_t                 res_status_reg;
    ple_pkg::status_t                 res_status_next;
    logic [ple_pkg::VAL_W-1:0]        res_data_reg;
    logic [ple_pkg::CAPACITY-1:0]     match_reg;
    logic                             m_tvalid_reg;
    logic                             m_tvalid_next;
    logic [ple_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic [ple_pkg::M_TDATA_W-1:0]    m_tdata_next;

    logic                             in_xfer;
    logic                             out_free;
    logic                             out_load;
    logic                             in_range;
    logic                             full;
    logic [ple_pkg::IDX_W-1:0]        pos_idx;
    ple_pkg::cell_ctrl_t              cell_ctrl;
    logic [ple_pkg::DATA_WIDTH-1:0]   cell_word [ple_pkg::CAPACITY];
    logic [ple_pkg::CAPACITY-1:0]     cell_match;
    logic                             pick_hit;
    logic [ple_pkg::IDX_W-1:0]        pick_index;
    ple_pkg::status_t                 fin_status;
    logic [ple_pkg::VAL_W-1:0]        fin_data;
    logic [ple_pkg::FPOS_W-1:0]       fin_fpos;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign pos_idx  = ple_pkg::IDX_W'(pos_reg);
    assign in_range = ple_pkg::CMP_W'(pos_reg) < ple_pkg::CMP_W'(count_reg);
    assign full     = count_reg == ple_pkg::CNT_W'(ple_pkg::CAPACITY);

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (in_xfer)
                    state_next = ple_pkg::S_EXEC;
            end
            ple_pkg::S_EXEC:
            begin
                state_next = ple_pkg::S_FIN;
            end
            ple_pkg::S_FIN:
            begin
                if (out_free)
                    state_next = in_xfer ? ple_pkg::S_EXEC : ple_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer: handshake outputs.
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            ple_pkg::S_FIN:
            begin
                s_tready = out_free;
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Decode of the held request into a cell operation, status and new count.
    always_comb
    begin
        cell_ctrl.op    = ple_pkg::CELL_HOLD;
        cell_ctrl.at    = pos_idx;
        res_status_next = ple_pkg::STAT_OK;
        count_next      = count_reg;
        if (state_reg == ple_pkg::S_EXEC)
        begin
            case (cmd_reg)
                ple_pkg::CMD_INS_AFTER, ple_pkg::CMD_INS_BEFORE:
                begin
                    if (!in_range)
                        res_status_next = ple_pkg::STAT_MISS;
                    else if (full)
                        res_status_next = ple_pkg::STAT_FULL;
                    else
                    begin
                        cell_ctrl.op = ple_pkg::CELL_INS;
                        if (cmd_reg == ple_pkg::CMD_INS_AFTER)
                            cell_ctrl.at = pos_idx + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ple_pkg::CMD_READ:
                begin
                    if (!in_range)
                        res_status_next = ple_pkg::STAT_MISS;
                end
                ple_pkg::CMD_WRITE:
                begin
                    if (!in_range)
                        res_status_next = ple_pkg::STAT_MISS;
                    else
                        cell_ctrl.op = ple_pkg::CELL_WR;
                end
                ple_pkg::CMD_DELETE:
                begin
                    if (!in_range)
                        res_status_next = ple_pkg::STAT_MISS;
                    else
                    begin
                        cell_ctrl.op = ple_pkg::CELL_DEL;
                        count_next   = count_reg - 1'b1;
                    end
                end
                ple_pkg::CMD_SEED:
                begin
                    cell_ctrl.op = ple_pkg::CELL_WR;
                    cell_ctrl.at = '0;
                    count_next   = ple_pkg::CNT_W'(1);
                end
                default:
                begin
                    res_status_next = ple_pkg::STAT_OK;
                end
            endcase
        end
    end

    // Chain of cells; each neighbor pair is wired both ways for shifting.
    for (genvar i = 0; i < ple_pkg::CAPACITY; i++)
    begin : g_cell
        logic [ple_pkg::DATA_WIDTH-1:0] left_w;
        logic [ple_pkg::DATA_WIDTH-1:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = cell_word[i-1];
        end
        if (i == ple_pkg::CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = cell_word[i+1];
        end
        ple_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .cell_index (ple_pkg::IDX_W'(i)),
            .count      (count_reg),
            .key        (key_reg),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .match      (cell_match[i])
        );
    end

    // First match over the registered compare results.
    ple_first_pick u_pick (
        .match_bits (match_reg),
        .hit        (pick_hit),
        .hit_index  (pick_index)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ple_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    // Request capture and the execute-cycle results.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= ple_pkg::cmd_t'(s_tdata[CMD_LO +: ple_pkg::CMD_W]);
            pos_reg <= s_tdata[POS_LO +: ple_pkg::POS_W];
            key_reg <= ple_pkg::to_word(s_tdata[VAL_LO +: ple_pkg::VAL_W]);
        end
        if (state_reg == ple_pkg::S_EXEC)
        begin
            res_status_reg <= res_status_next;
            match_reg      <= cell_match;
            if (cmd_reg == ple_pkg::CMD_READ && in_range)
                res_data_reg <= ple_pkg::to_field(cell_word[pos_idx]);
            else
                res_data_reg <= '0;
        end
        if (out_load)
            m_tdata_reg <= m_tdata_next;
    end

    // Result assembly in the final cycle.
    always_comb
    begin
        fin_status = res_status_reg;
        fin_data   = res_data_reg;
        fin_fpos   = '0;
        if (cmd_reg == ple_pkg::CMD_FIND)
        begin
            if (pick_hit)
            begin
                fin_status = ple_pkg::STAT_OK;
                fin_data   = ple_pkg::to_field(key_reg);
                fin_fpos   = ple_pkg::FPOS_W'(pick_index);
            end
            else
            begin
                fin_status = ple_pkg::STAT_MISS;
                fin_data   = '0;
            end
        end
        m_tdata_next = ple_pkg::M_TDATA_W'({ple_pkg::LEN_W'(count_reg), fin_fpos,
                                            fin_data, fin_status});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Keeps the payload width tied to the field list.
    localparam int PAY_CHECK = (PAY_W <= ple_pkg::M_TDATA_W) ? 1 : 0;
    if (PAY_CHECK == 0)
    begin : g_bad_width
        $error("Result payload does not fit the output bus.");
    end

endmodule

// File: sv/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_engine_core_defines.svh"

module ple_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [1:0]  status;
    logic [31:0] data;
    logic [8:0]  length;
    logic        in_xfer;
    logic        out_held;
    logic        full_res;
    logic        at_capacity;
    logic        fail_res;
    logic        fail_ok;

    assign status      = m_tdata[1:0];
    assign data        = m_tdata[33:2];
    assign length      = m_tdata[50:42];
    assign in_xfer     = s_tvalid && s_tready;
    assign out_held    = m_tvalid && !m_tready;
    assign full_res    = m_tvalid && (status == 2'd2);
    assign at_capacity = length == 9'(ple_pkg::CAPACITY);
    assign fail_res    = m_tvalid && (status != 2'd0);
    assign fail_ok     = (data == 32'd0) && (status != 2'd3);

    // A held result stays offered.
    `PLE_ASSERT_NEXT(a_hold, clk, rst_n, out_held, m_tvalid, "result dropped while stalled")

    // The engine is busy for the cycle after it takes a request.
    `PLE_ASSERT_NEXT(a_busy, clk, rst_n, in_xfer, !s_tready, "request taken during execution")

    // A refused insert is reported only with a full list.
    `PLE_ASSERT_NOW(a_full, clk, rst_n, full_res, at_capacity, "full status with room left")

    // Any failure carries zero data and no status code beyond full.
    `PLE_ASSERT_NOW(a_fail, clk, rst_n, fail_res, fail_ok, "bad failure result")

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (.*);

// File: tb/positional_list_engine_core_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb
// Self-checking testbench for the positional list engine.
// ----------------------------------------------------------------------------
// Requests go in over the slave stream and are mirrored in a shadow list
// that predicts each result at the moment the request transfer happens.
// Results coming out of the master stream are compared field by field with
// the oldest prediction. Directed tests cover the empty list, every command,
// the value extremes and a full list. A back-pressure test and a long random
// run follow. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ITEMS = 1600;

    // One predicted result of the engine.
    typedef struct {
        ple_pkg::cmd_t    cmd;
        ple_pkg::status_t status;
        logic [31:0]      data;
        logic [7:0]       fpos;
        logic [8:0]       len;
    } list_result_t;

    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ple_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ple_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the list contents, front element first.
    logic [31:0]  shadow_list[$];
    list_result_t pending_results[$];
    int           mismatch_count = 0;
    int           hold_request   = 0;
    bit           sender_quiet   = 1'b0;

    logic [31:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                                    32'hAAAA_AAAA, 32'h0000_002A};

    positional_list_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Applies one request to the shadow list and returns its result.
    function automatic list_result_t list_predict(ple_pkg::cmd_t cmd, logic [7:0] pos,
                                                  logic [31:0] val);
        list_result_t r;
        int           n;
        bit           in_range;
        n          = shadow_list.size();
        in_range   = pos < n;
        r.cmd      = cmd;
        r.status   = ple_pkg::STAT_OK;
        r.data     = '0;
        r.fpos     = '0;
        case (cmd)
            ple_pkg::CMD_INS_AFTER, ple_pkg::CMD_INS_BEFORE:
            begin
                if (!in_range)
                    r.status = ple_pkg::STAT_MISS;
                else if (n >= ple_pkg::CAPACITY)
                    r.status = ple_pkg::STAT_FULL;
                else
                    shadow_list.insert((cmd == ple_pkg::CMD_INS_AFTER) ? int'(pos) + 1
                                                                       : int'(pos),
                                       val);
            end
            ple_pkg::CMD_READ:
            begin
                if (!in_range)
                    r.status = ple_pkg::STAT_MISS;
                else
                    r.data = shadow_list[pos];
            end
            ple_pkg::CMD_FIND:
            begin
                r.status = ple_pkg::STAT_MISS;
                for (int k = 0; k < n; k++)
                begin
                    if (shadow_list[k] == val)
                    begin
                        r.status = ple_pkg::STAT_OK;
                        r.data   = val;
                        r.fpos   = k[7:0];
                        break;
                    end
                end
            end
            ple_pkg::CMD_WRITE:
            begin
                if (!in_range)
                    r.status = ple_pkg::STAT_MISS;
                else
                    shadow_list[pos] = val;
            end
            ple_pkg::CMD_DELETE:
            begin
                if (!in_range)
                    r.status = ple_pkg::STAT_MISS;
                else
                    shadow_list.delete(pos);
            end
            ple_pkg::CMD_SEED:
            begin
                shadow_list.delete();
                shadow_list.push_back(val);
            end
            default: ;
        endcase
        r.len = 9'(shadow_list.size());
        return r;
    endfunction

    // Sends one request; called at a falling edge and returns at one.
    task automatic send_request(input ple_pkg::cmd_t cmd, input logic [7:0] pos,
                                input logic [31:0] val);
        int gap;
        gap = pick_gap(sender_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ple_pkg::S_TDATA_W'({val, pos, cmd});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(list_predict(cmd, pos, val));
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Every command against an empty list, then seed and empty again.
    task automatic test_empty_list();
        send_request(ple_pkg::CMD_INS_AFTER, 8'd0, 32'h1234_5678);
        send_request(ple_pkg::CMD_INS_BEFORE, 8'd255, 32'hFFFF_FFFF);
        send_request(ple_pkg::CMD_READ, 8'd0, 32'h0);
        send_request(ple_pkg::CMD_FIND, 8'd0, 32'h0);
        send_request(ple_pkg::CMD_WRITE, 8'd0, 32'h8000_0000);
        send_request(ple_pkg::CMD_DELETE, 8'd0, 32'h0);
        send_request(ple_pkg::CMD_SEED, 8'd255, 32'h8000_0000);
        send_request(ple_pkg::CMD_DELETE, 8'd0, 32'h0);
        send_request(ple_pkg::CMD_INS_AFTER, 8'd0, 32'h7FFF_FFFF);
        drain_results();
    endtask

    // Each command with the value extremes, hits and misses.
    task automatic test_basic_ops();
        send_request(ple_pkg::CMD_SEED, 8'd0, 32'h7FFF_FFFF);
        send_request(ple_pkg::CMD_INS_AFTER, 8'd0, 32'h8000_0000);
        send_request(ple_pkg::CMD_INS_BEFORE, 8'd0, 32'hFFFF_FFFF);
        send_request(ple_pkg::CMD_READ, 8'd0, 32'h0);
        send_request(ple_pkg::CMD_READ, 8'd1, 32'h0);
        send_request(ple_pkg::CMD_READ, 8'd2, 32'h0);
        send_request(ple_pkg::CMD_READ, 8'd3, 32'h0);
        send_request(ple_pkg::CMD_FIND, 8'd0, 32'h8000_0000);
        send_request(ple_pkg::CMD_FIND, 8'd0, 32'h0000_0000);
        send_request(ple_pkg::CMD_INS_AFTER, 8'd1, 32'h0000_0000);
        send_request(ple_pkg::CMD_INS_BEFORE, 8'd3, 32'h0000_0001);
        send_request(ple_pkg::CMD_WRITE, 8'd4, 32'h5555_5555);
        send_request(ple_pkg::CMD_WRITE, 8'd5, 32'hAAAA_AAAA);
        send_request(ple_pkg::CMD_FIND, 8'd0, 32'h5555_5555);
        send_request(ple_pkg::CMD_DELETE, 8'd4, 32'h0);
        send_request(ple_pkg::CMD_DELETE, 8'd0, 32'h0);
        send_request(ple_pkg::CMD_DELETE, 8'd3, 32'h0);
        send_request(ple_pkg::CMD_READ, 8'd255, 32'h0);
        send_request(ple_pkg::CMD_INS_AFTER, 8'd2, 32'h7FFF_FFFF);
        send_request(ple_pkg::CMD_FIND, 8'd0, 32'h7FFF_FFFF);
        drain_results();
    endtask

    // Grows the list to full capacity and probes the full case.
    task automatic test_fill_to_capacity();
        int n;
        send_request(ple_pkg::CMD_SEED, 8'd0, $urandom);
        while (shadow_list.size() < ple_pkg::CAPACITY)
        begin
            n = shadow_list.size();
            send_request($urandom_range(0, 1) ? ple_pkg::CMD_INS_AFTER
                                              : ple_pkg::CMD_INS_BEFORE,
                         8'($urandom_range(0, n - 1)), $urandom);
        end
        send_request(ple_pkg::CMD_INS_AFTER, 8'd255, 32'h0000_0001);
        send_request(ple_pkg::CMD_INS_BEFORE, 8'd0, 32'hFFFF_FFFF);
        send_request(ple_pkg::CMD_READ, 8'd255, 32'h0);
        send_request(ple_pkg::CMD_FIND, 8'd0, shadow_list[255]);
        send_request(ple_pkg::CMD_WRITE, 8'd255, 32'h8000_0000);
        send_request(ple_pkg::CMD_FIND, 8'd0, 32'h8000_0000);
        send_request(ple_pkg::CMD_DELETE, 8'd128, 32'h0);
        send_request(ple_pkg::CMD_INS_BEFORE, 8'd254, 32'h7FFF_FFFF);
        send_request(ple_pkg::CMD_DELETE, 8'd255, 32'h0);
        send_request(ple_pkg::CMD_READ, 8'd255, 32'h0);
        send_request(ple_pkg::CMD_SEED, 8'd0, 32'h0000_002A);
        drain_results();
    endtask

    // Result side holds off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        @(posedge clk);
        hold_request = 300;
        @(negedge clk);
        sender_quiet = 1'b1;
        repeat (40)
            send_request($urandom_range(0, 1) ? ple_pkg::CMD_INS_AFTER : ple_pkg::CMD_READ,
                         8'd0, $urandom);
        sender_quiet = 1'b0;
        drain_results();
    endtask

    // Random traffic that alternates between growing and shrinking epochs.
    task automatic test_random_traffic();
        ple_pkg::cmd_t cmd;
        logic [7:0]    pos;
        logic [31:0]   val;
        int            n;
        int            r;
        int            p;
        int            calm_items;
        bit            grow;
        calm_items = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            n    = shadow_list.size();
            grow = ((i / 200) % 2) == 0;
            r    = $urandom_range(0, 99);
            if (n == 0 && r < 60)
                cmd = ple_pkg::CMD_SEED;
            else if (r < (grow ? 35 : 15))
                cmd = $urandom_range(0, 1) ? ple_pkg::CMD_INS_AFTER
                                           : ple_pkg::CMD_INS_BEFORE;
            else if (r < 50)
                cmd = ple_pkg::CMD_DELETE;
            else if (r < 65)
                cmd = ple_pkg::CMD_READ;
            else if (r < 80)
                cmd = ple_pkg::CMD_FIND;
            else if ($urandom_range(0, 9) == 0)
                cmd = ple_pkg::CMD_SEED;
            else
                cmd = ple_pkg::CMD_WRITE;

            // Positions mostly inside the list, with the ends and misses favored.
            p = $urandom_range(0, 19);
            if (n == 0 || p == 0)
                pos = 8'($urandom_range(0, 255));
            else if (p == 1)
                pos = 8'(n - 1);
            else if (p == 2)
                pos = 8'd0;
            else if (p == 3 && n < 256)
                pos = 8'(n);
            else
                pos = 8'($urandom_range(0, n - 1));

            // Values from a small pool so that finds hit, or fully random.
            r = $urandom_range(0, 9);
            if (cmd == ple_pkg::CMD_FIND && n > 0 && r < 6)
                val = shadow_list[$urandom_range(0, n - 1)];
            else if (r < 4)
                val = value_pool[$urandom_range(0, 7)];
            else
                val = $urandom;

            // Now and then a stretch of requests without gaps.
            if (calm_items > 0)
                calm_items--;
            else if ($urandom_range(0, 49) == 0)
                calm_items = $urandom_range(20, 80);
            sender_quiet = calm_items > 0;

            send_request(cmd, pos, val);
        end
        sender_quiet = 1'b0;
        drain_results();
    endtask

    // Result receiver: random stalls, calm stretches and requested hold-offs.
    initial
    begin
        int hold_left;
        int stall_left;
        int calm_left;
        hold_left  = 0;
        stall_left = 0;
        calm_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = $urandom_range(50, 300);
                else
                    stall_left = pick_gap(1'b0);
            end
        end
    end

    // Logs one field mismatch; only the first few are printed.
    task automatic report_field(input string field, input ple_pkg::cmd_t cmd,
                                input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch on %s result: expected %h, got %h",
                     $realtime, field, cmd.name(), want, got);
    endtask

    // Result checker: each result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result %h arrived with none pending",
                             $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_field("status", want.cmd, 32'(want.status), 32'(m_tdata[1:0]));
                if (m_tdata[33:2] !== want.data)
                    report_field("data_out", want.cmd, want.data, m_tdata[33:2]);
                if (m_tdata[41:34] !== want.fpos)
                    report_field("found_position", want.cmd, 32'(want.fpos),
                                 32'(m_tdata[41:34]));
                if (m_tdata[50:42] !== want.len)
                    report_field("list_length", want.cmd, 32'(want.len),
                                 32'(m_tdata[50:42]));
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_basic_ops();
        test_fill_to_capacity();
        test_output_stall();
        test_random_traffic();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
